@@ rtl/core/psf15_pkg.sv @@
package psf15_pkg;

  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned CRD_W     = 16;
  localparam int unsigned FAC_W     = 22;
  localparam int unsigned AB_W      = 2 * FAC_W;
  localparam int unsigned SPLIT_W   = FAC_W;
  localparam int unsigned PLO_W     = SPLIT_W + 1 + FAC_W;
  localparam int unsigned PHI_W     = (AB_W - SPLIT_W) + FAC_W;
  localparam int unsigned SUM_W     = PHI_W + SPLIT_W + 2;
  localparam int unsigned RND_SHIFT = 2 * FRAC_BITS + 1;
  localparam int unsigned RND_W     = SUM_W - RND_SHIFT;
  localparam int unsigned OUT_W     = 19;

  typedef enum logic [1:0] {
    CMD_VALUE = 2'd0,
    CMD_DR    = 2'd1,
    CMD_DS    = 2'd2,
    CMD_DT    = 2'd3
  } cmd_e;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic en5;
  } pipe_en_t;

endpackage

@@ rtl/core/psf15_if.sv @@
interface psf15_in_if;
  import psf15_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              command;
  logic [3:0]              node_index;
  logic signed [CRD_W-1:0] coord_r;
  logic signed [CRD_W-1:0] coord_s;
  logic signed [CRD_W-1:0] coord_t;
  modport source (output valid, command, node_index, coord_r, coord_s, coord_t, input ready);
  modport sink   (input valid, command, node_index, coord_r, coord_s, coord_t, output ready);
endinterface

interface psf15_out_if;
  import psf15_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] result_value;
  logic                    saturated;
  modport source (output valid, result_value, saturated, input ready);
  modport sink   (input valid, result_value, saturated, output ready);
endinterface

@@ rtl/core/prism15_shape_function_eval_top.sv @@
// channel  | dir | payload
// in_i     | in  | command, node_index, coord_r, coord_s, coord_t
// out_o    | out | result_value, saturated
//
// Five register stages: factors, a*b, split partial products, sum and
// round, saturate. One word per cycle while the output is not stalled.
// The rate is set by the multiplier stages, each fully pipelined.
// rst_ni clears the stage valid bits only.
// Each stage advances when it is empty or the next one advances, so a
// stalled output lets bubbles close up; nothing is dropped or repeated.
module prism15_shape_function_eval_top
  import psf15_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  psf15_in_if.sink    in_i,
  psf15_out_if.source out_o
);

  pipe_en_t                en;
  logic                    v1, v3, v4_unused_free;
  logic signed [FAC_W-1:0] fa, fb, fc;
  logic signed [PLO_W-1:0] plo;
  logic signed [PHI_W-1:0] phi;
  logic                    v2_q, v4_q;

  // shadow valid bits of the inner stages for the enable chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en.en2) v2_q <= v1;
      if (en.en4) v4_q <= v3;
    end
  end

  assign v4_unused_free = !v4_q;

  always_comb begin
    en.en5 = !out_o.valid || out_o.ready;
    en.en4 = v4_unused_free || en.en5;
    en.en3 = !v3 || en.en4;
    en.en2 = !v2_q || en.en3;
    en.en1 = !v1 || en.en2;
  end

  assign in_i.ready = en.en1;

  psf15_factor u_factor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en.en1),
    .valid_i      (in_i.valid),
    .command_i    (in_i.command),
    .node_index_i (in_i.node_index),
    .coord_r_i    (in_i.coord_r),
    .coord_s_i    (in_i.coord_s),
    .coord_t_i    (in_i.coord_t),
    .valid_o      (v1),
    .fac_a_o      (fa),
    .fac_b_o      (fb),
    .fac_c_o      (fc)
  );

  psf15_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (v1),
    .fac_a_i   (fa),
    .fac_b_i   (fb),
    .fac_c_i   (fc),
    .valid_o   (v3),
    .prod_lo_o (plo),
    .prod_hi_o (phi)
  );

  psf15_round u_round (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (v3),
    .prod_lo_i      (plo),
    .prod_hi_i      (phi),
    .valid_o        (out_o.valid),
    .result_value_o (out_o.result_value),
    .saturated_o    (out_o.saturated)
  );

  a_full_only_when_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled while output free");

  a_sat_clips : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.saturated) |->
      (out_o.result_value == {1'b0, {(OUT_W-1){1'b1}}} ||
       out_o.result_value == {1'b1, {(OUT_W-1){1'b0}}}))
    else $error("saturated word not at a range limit");

  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v1)
    else $error("accepted word lost in first stage");

endmodule

@@ rtl/core/psf15_factor.sv @@
module psf15_factor
  import psf15_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [1:0]              command_i,
  input  logic [3:0]              node_index_i,
  input  logic signed [CRD_W-1:0] coord_r_i,
  input  logic signed [CRD_W-1:0] coord_s_i,
  input  logic signed [CRD_W-1:0] coord_t_i,
  output logic                    valid_o,
  output logic signed [FAC_W-1:0] fac_a_o,
  output logic signed [FAC_W-1:0] fac_b_o,
  output logic signed [FAC_W-1:0] fac_c_o
);

  localparam logic signed [FAC_W-1:0] One = FAC_W'(1) << FRAC_BITS;
  localparam logic signed [FAC_W-1:0] K2  = FAC_W'(2);
  localparam logic signed [FAC_W-1:0] K4  = FAC_W'(4);

  logic signed [FAC_W-1:0] r, s, t, u, x, y;
  logic signed [FAC_W-1:0] a_d, b_d, c_d, a_q, b_q, c_q;
  logic                    valid_q;
  logic                    dr;

  always_comb begin
    r  = FAC_W'(coord_r_i);
    s  = FAC_W'(coord_s_i);
    t  = FAC_W'(coord_t_i);
    u  = One - r - s;
    dr = (command_i == CMD_DR);
    x  = dr ? r : s;
    y  = dr ? s : r;
    a_d = '0;
    b_d = '0;
    c_d = '0;
    case (cmd_e'(command_i))
      CMD_VALUE: begin
        case (node_index_i)
          4'd0:  begin a_d = t - One; b_d = u; c_d = t + K2*s + K2*r; end
          4'd1:  begin a_d = r; b_d = One - t; c_d = K2*r - K2*One - t; end
          4'd2:  begin a_d = s; b_d = One - t; c_d = K2*s - K2*One - t; end
          4'd3:  begin a_d = -t - One; b_d = u; c_d = -t + K2*s + K2*r; end
          4'd4:  begin a_d = r; b_d = One + t; c_d = K2*r - K2*One + t; end
          4'd5:  begin a_d = s; b_d = One + t; c_d = K2*s - K2*One + t; end
          4'd6:  begin a_d = K4*r; b_d = u; c_d = One - t; end
          4'd7:  begin a_d = K4*s; b_d = u; c_d = One - t; end
          4'd8:  begin a_d = K2*u; b_d = One - t; c_d = One + t; end
          4'd9:  begin a_d = K4*s; b_d = r; c_d = One - t; end
          4'd10: begin a_d = K2*r; b_d = One - t; c_d = One + t; end
          4'd11: begin a_d = K2*s; b_d = One - t; c_d = One + t; end
          4'd12: begin a_d = K4*r; b_d = u; c_d = One + t; end
          4'd13: begin a_d = K4*s; b_d = u; c_d = One + t; end
          4'd14: begin a_d = K4*s; b_d = r; c_d = One + t; end
          default: ;
        endcase
      end
      CMD_DR, CMD_DS: begin
        c_d = One;
        case (node_index_i)
          4'd0:  begin a_d = t - One; b_d = K2*u - t - K2*s - K2*r; end
          4'd3:  begin a_d = -t - One; b_d = K2*u + t - K2*s - K2*r; end
          4'd8:  begin a_d = -K2*(One - t); b_d = One + t; end
          4'd1:  if (dr) begin a_d = One - t; b_d = K4*x - K2*One - t; end
          4'd2:  if (!dr) begin a_d = One - t; b_d = K4*x - K2*One - t; end
          4'd4:  if (dr) begin a_d = One + t; b_d = K4*x - K2*One + t; end
          4'd5:  if (!dr) begin a_d = One + t; b_d = K4*x - K2*One + t; end
          4'd10: if (dr) begin a_d = K2*(One - t); b_d = One + t; end
          4'd11: if (!dr) begin a_d = K2*(One - t); b_d = One + t; end
          4'd6:  begin a_d = dr ? K4*u - K4*r : -K4*r; b_d = One - t; end
          4'd7:  begin a_d = dr ? -K4*s : K4*u - K4*s; b_d = One - t; end
          4'd9:  begin a_d = K4*y; b_d = One - t; end
          4'd12: begin a_d = dr ? K4*u - K4*r : -K4*r; b_d = One + t; end
          4'd13: begin a_d = dr ? -K4*s : K4*u - K4*s; b_d = One + t; end
          4'd14: begin a_d = K4*y; b_d = One + t; end
          default: c_d = '0;
        endcase
      end
      default: begin
        c_d = One;
        case (node_index_i)
          4'd0:  begin a_d = u; b_d = K2*t + K2*s + K2*r - One; end
          4'd1:  begin a_d = r; b_d = K2*t + One - K2*r; end
          4'd2:  begin a_d = s; b_d = K2*t + One - K2*s; end
          4'd3:  begin a_d = u; b_d = K2*t - K2*s - K2*r + One; end
          4'd4:  begin a_d = r; b_d = K2*r - One + K2*t; end
          4'd5:  begin a_d = s; b_d = K2*s - One + K2*t; end
          4'd6:  begin a_d = -K4*r; b_d = u; end
          4'd7:  begin a_d = -K4*s; b_d = u; end
          4'd8:  begin a_d = -K4*u; b_d = t; end
          4'd9:  begin a_d = -K4*r; b_d = s; end
          4'd10: begin a_d = -K4*r; b_d = t; end
          4'd11: begin a_d = -K4*s; b_d = t; end
          4'd12: begin a_d = K4*r; b_d = u; end
          4'd13: begin a_d = K4*s; b_d = u; end
          4'd14: begin a_d = K4*r; b_d = s; end
          default: c_d = '0;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
    end
  end

  assign valid_o = valid_q;
  assign fac_a_o = a_q;
  assign fac_b_o = b_q;
  assign fac_c_o = c_q;

endmodule

@@ rtl/core/psf15_mul.sv @@
module psf15_mul
  import psf15_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pipe_en_t                en_i,
  input  logic                    valid_i,
  input  logic signed [FAC_W-1:0] fac_a_i,
  input  logic signed [FAC_W-1:0] fac_b_i,
  input  logic signed [FAC_W-1:0] fac_c_i,
  output logic                    valid_o,
  output logic signed [PLO_W-1:0] prod_lo_o,
  output logic signed [PHI_W-1:0] prod_hi_o
);

  logic signed [AB_W-1:0]  ab_d, ab_q;
  logic signed [FAC_W-1:0] c2_q;
  logic signed [PLO_W-1:0] lo_d, lo_q;
  logic signed [PHI_W-1:0] hi_d, hi_q;
  logic                    v2_q, v3_q;

  assign ab_d = AB_W'(fac_a_i) * AB_W'(fac_b_i);

  // split a*b so that each multiply takes one part of a*b, at most one bit wider than a factor
  always_comb begin
    lo_d = PLO_W'($signed({1'b0, ab_q[SPLIT_W-1:0]})) * PLO_W'(c2_q);
    hi_d = PHI_W'($signed(ab_q[AB_W-1:SPLIT_W])) * PHI_W'(c2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en_i.en2) v2_q <= valid_i;
      if (en_i.en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en2) begin
      ab_q <= ab_d;
      c2_q <= fac_c_i;
    end
    if (en_i.en3) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  assign valid_o   = v3_q;
  assign prod_lo_o = lo_q;
  assign prod_hi_o = hi_q;

endmodule

@@ rtl/core/psf15_round.sv @@
module psf15_round
  import psf15_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pipe_en_t                en_i,
  input  logic                    valid_i,
  input  logic signed [PLO_W-1:0] prod_lo_i,
  input  logic signed [PHI_W-1:0] prod_hi_i,
  output logic                    valid_o,
  output logic signed [OUT_W-1:0] result_value_o,
  output logic                    saturated_o
);

  localparam logic signed [SUM_W-1:0] Half = SUM_W'(1) << (RND_SHIFT - 1);
  localparam logic signed [OUT_W-1:0] OutMax = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OutMin = {1'b1, {(OUT_W-1){1'b0}}};

  logic signed [SUM_W-1:0] sum;
  logic signed [RND_W-1:0] rnd_d, rnd_q;
  logic signed [OUT_W-1:0] res_d, res_q;
  logic                    sat_d, sat_q;
  logic                    v4_q, v5_q;
  logic                    in_range;

  // twice the value, then round half up and halve in one shift
  always_comb begin
    sum   = (SUM_W'(prod_hi_i) <<< SPLIT_W) + SUM_W'(prod_lo_i) + Half;
    rnd_d = RND_W'(sum >>> RND_SHIFT);
  end

  always_comb begin
    in_range = (rnd_q[RND_W-1:OUT_W-1] == '0) || (rnd_q[RND_W-1:OUT_W-1] == '1);
    sat_d    = !in_range;
    if (in_range) begin
      res_d = rnd_q[OUT_W-1:0];
    end else if (rnd_q[RND_W-1]) begin
      res_d = OutMin;
    end else begin
      res_d = OutMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en_i.en4) v4_q <= valid_i;
      if (en_i.en5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en4) rnd_q <= rnd_d;
    if (en_i.en5) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign valid_o        = v5_q;
  assign result_value_o = res_q;
  assign saturated_o    = sat_q;

endmodule

@@ tb/sv/prism15_shape_function_eval_top_test.sv @@
`timescale 1ns / 100ps

module prism15_shape_function_eval_top_test;
  import psf15_pkg::*;

  localparam longint ONE        = longint'(1) << FRAC_BITS;
  localparam int     STALL_MAX  = 4000;
  localparam int     DRAIN_WAIT = 12;

  typedef struct {
    logic signed [OUT_W-1:0] value;
    logic                    sat;
  } shape_res_t;

  logic clk;
  logic rst_n;
  logic no_idle;
  int   errors;
  int   stall_cycles;

  shape_res_t shape_q[$];

  psf15_in_if  in_ch ();
  psf15_out_if out_ch ();

  prism15_shape_function_eval_top DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Shape function or derivative, rounded half up and saturated
  function automatic shape_res_t shape_eval(cmd_e cmd, logic [3:0] node,
                                            logic signed [15:0] rc,
                                            logic signed [15:0] sc,
                                            logic signed [15:0] tc);
    longint r, s, t, u, a, b, c;
    logic signed [127:0] w;
    shape_res_t res;
    bit dr;
    r = rc; s = sc; t = tc;
    u = ONE - r - s;
    a = 0; b = 0; c = 0;
    dr = (cmd == CMD_DR);
    case (cmd)
      CMD_VALUE: begin
        case (node)
          0:  begin a = t - ONE;  b = u;       c = t + 2*s + 2*r;       end
          1:  begin a = r;        b = ONE - t; c = 2*r - 2*ONE - t;     end
          2:  begin a = s;        b = ONE - t; c = 2*s - 2*ONE - t;     end
          3:  begin a = -t - ONE; b = u;       c = -t + 2*s + 2*r;      end
          4:  begin a = r;        b = ONE + t; c = 2*r - 2*ONE + t;     end
          5:  begin a = s;        b = ONE + t; c = 2*s - 2*ONE + t;     end
          6:  begin a = 4*r;      b = u;       c = ONE - t;             end
          7:  begin a = 4*s;      b = u;       c = ONE - t;             end
          8:  begin a = 2*u;      b = ONE - t; c = ONE + t;             end
          9:  begin a = 4*s;      b = r;       c = ONE - t;             end
          10: begin a = 2*r;      b = ONE - t; c = ONE + t;             end
          11: begin a = 2*s;      b = ONE - t; c = ONE + t;             end
          12: begin a = 4*r;      b = u;       c = ONE + t;             end
          13: begin a = 4*s;      b = u;       c = ONE + t;             end
          14: begin a = 4*s;      b = r;       c = ONE + t;             end
          default: ;
        endcase
      end
      CMD_DR, CMD_DS: begin
        c = ONE;
        case (node)
          0:  begin a = t - ONE;  b = 2*u - t - 2*s - 2*r; end
          3:  begin a = -t - ONE; b = 2*u + t - 2*s - 2*r; end
          8:  begin a = -2*(ONE - t); b = ONE + t; end
          1:  if (dr) begin a = ONE - t; b = 4*r - 2*ONE - t; end
          2:  if (!dr) begin a = ONE - t; b = 4*s - 2*ONE - t; end
          4:  if (dr) begin a = ONE + t; b = 4*r - 2*ONE + t; end
          5:  if (!dr) begin a = ONE + t; b = 4*s - 2*ONE + t; end
          10: if (dr) begin a = 2*(ONE - t); b = ONE + t; end
          11: if (!dr) begin a = 2*(ONE - t); b = ONE + t; end
          6:  begin a = dr ? 4*u - 4*r : -4*r; b = ONE - t; end
          7:  begin a = dr ? -4*s : 4*u - 4*s; b = ONE - t; end
          9:  begin a = dr ? 4*s : 4*r;        b = ONE - t; end
          12: begin a = dr ? 4*u - 4*r : -4*r; b = ONE + t; end
          13: begin a = dr ? -4*s : 4*u - 4*s; b = ONE + t; end
          14: begin a = dr ? 4*s : 4*r;        b = ONE + t; end
          default: c = 0;
        endcase
      end
      default: begin
        c = ONE;
        case (node)
          0:  begin a = u;    b = 2*t + 2*s + 2*r - ONE; end
          1:  begin a = r;    b = 2*t + ONE - 2*r;       end
          2:  begin a = s;    b = 2*t + ONE - 2*s;       end
          3:  begin a = u;    b = 2*t - 2*s - 2*r + ONE; end
          4:  begin a = r;    b = 2*r - ONE + 2*t;       end
          5:  begin a = s;    b = 2*s - ONE + 2*t;       end
          6:  begin a = -4*r; b = u; end
          7:  begin a = -4*s; b = u; end
          8:  begin a = -4*u; b = t; end
          9:  begin a = -4*r; b = s; end
          10: begin a = -4*r; b = t; end
          11: begin a = -4*s; b = t; end
          12: begin a = 4*r;  b = u; end
          13: begin a = 4*s;  b = u; end
          14: begin a = 4*r;  b = s; end
          default: c = 0;
        endcase
      end
    endcase
    // twice the value in units of 2^-(3*FRAC_BITS)
    w = a;
    w = w * b;
    w = w * c;
    w = w + (128'sd1 <<< (RND_SHIFT - 1));
    w = w >>> RND_SHIFT;
    res.sat = 1'b1;
    if (w > 128'sd262143) res.value = 19'sd262143;
    else if (w < -128'sd262144) res.value = -19'sd262144;
    else begin
      res.value = w[OUT_W-1:0];
      res.sat   = 1'b0;
    end
    return res;
  endfunction

  // Predict on input word, check on output word, watch for a hang
  always @(posedge clk) begin
    shape_res_t exp_res;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        shape_q.push_back(shape_eval(cmd_e'(in_ch.command), in_ch.node_index,
                                     in_ch.coord_r, in_ch.coord_s, in_ch.coord_t));
      if (out_ch.valid && out_ch.ready) begin
        if (shape_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word value %0d sat %0b", $time,
                   out_ch.result_value, out_ch.saturated);
        end else begin
          exp_res = shape_q.pop_front();
          if (out_ch.result_value !== exp_res.value) begin
            errors++;
            $display("%0t: result_value expected %0d actual %0d", $time,
                     exp_res.value, out_ch.result_value);
          end
          if (out_ch.saturated !== exp_res.sat) begin
            errors++;
            $display("%0t: saturated expected %0b actual %0b", $time,
                     exp_res.sat, out_ch.saturated);
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_MAX) begin
        $display("prism15_shape_function_eval_top verification failed");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= no_idle || ($urandom_range(99) >= 11);
  end

  task automatic send_word(cmd_e cmd, logic [3:0] node, logic [15:0] r,
                           logic [15:0] s, logic [15:0] t);
    if (!no_idle && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.node_index <= node;
    in_ch.coord_r    <= r;
    in_ch.coord_s    <= s;
    in_ch.coord_t    <= t;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (shape_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [3:0] n;
    // every node once, commands rotating, at element points
    for (int i = 0; i < 16; i++) begin
      n = 4'(i);
      send_word(cmd_e'(i % 4), n, 16'(ONE / 3 * (i % 3)), 16'(ONE / 4), 16'(-ONE + i * 2048));
    end
    // extremes drive the saturation in both directions
    send_word(CMD_VALUE, 4'd0, 16'h8000, 16'h8000, 16'h8000);
    send_word(CMD_VALUE, 4'd3, 16'h7fff, 16'h7fff, 16'h7fff);
    send_word(CMD_DR, 4'd6, 16'h8000, 16'h7fff, 16'h8000);
    send_word(CMD_DS, 4'd7, 16'h7fff, 16'h8000, 16'h7fff);
    send_word(CMD_DT, 4'd8, 16'h8000, 16'h8000, 16'h7fff);
    send_word(CMD_DT, 4'd15, 16'h7fff, 16'h7fff, 16'h7fff);
    send_word(CMD_DR, 4'd1, 16'h0000, 16'h0000, 16'h0000);
    send_word(CMD_VALUE, 4'd12, 16'h7fff, 16'h8000, 16'h7fff);
  endtask

  task automatic test_random(int count);
    logic [15:0] cr, cs, ct;
    for (int i = 0; i < count; i++) begin
      no_idle <= (i >= 400 && i < 600);
      if ($urandom_range(99) < 70) begin
        cr = 16'($signed($urandom_range(0, 2 * ONE)) - ONE);
        cs = 16'($signed($urandom_range(0, 2 * ONE)) - ONE);
        ct = 16'($signed($urandom_range(0, 2 * ONE)) - ONE);
      end else begin
        cr = 16'($urandom);
        cs = 16'($urandom);
        ct = 16'($urandom);
      end
      send_word(cmd_e'($urandom_range(3)), 4'($urandom_range(15)), cr, cs, ct);
    end
    no_idle <= 1'b0;
  endtask

  task automatic test_pause_drain();
    for (int i = 0; i < 20; i++)
      send_word(cmd_e'($urandom_range(3)), 4'($urandom_range(15)), 16'($urandom),
                16'($urandom), 16'($urandom));
    wait_drained();
    for (int i = 0; i < 20; i++)
      send_word(cmd_e'($urandom_range(3)), 4'($urandom_range(15)), 16'($urandom),
                16'($urandom), 16'($urandom));
  endtask

  initial begin
    errors           = 0;
    stall_cycles     = 0;
    no_idle          = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_VALUE;
    in_ch.node_index = '0;
    in_ch.coord_r    = '0;
    in_ch.coord_s    = '0;
    in_ch.coord_t    = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pause_drain();
    test_random(1200);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && shape_q.size() == 0)
      $display("prism15_shape_function_eval_top verification clean");
    else
      $display("prism15_shape_function_eval_top verification failed");
    $finish;
  end

endmodule
